### rtl/iadc_pkg.sv
// shared types and constants for the irq and dma control register block
// no dependencies; used by iadc_dma_regs and irq_and_dma_control_registers
`default_nettype none

package iadc_pkg;

    // number of dma channels (7 or 8)
    localparam int NUM_CHANNELS = 7;
    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam logic [3:0] NUM_CH_CMP = 4'(NUM_CHANNELS);

    // word kinds carried on s_tuser
    typedef enum logic [2:0] {
        ACT_IRQ_WR = 3'd0,
        ACT_IRQ_RD = 3'd1,
        ACT_DMA_WR = 3'd2,
        ACT_DMA_RD = 3'd3,
        ACT_RAISE  = 3'd4
    } action_t;

    // irq register offsets
    localparam logic [4:0] IRQ_OFF_STATUS = 5'd0;
    localparam logic [4:0] IRQ_OFF_ENABLE = 5'd1;

    // dma register slots within a channel or the control group
    localparam logic [1:0] SLOT_BASE    = 2'd0;
    localparam logic [1:0] SLOT_BLOCK   = 2'd1;
    localparam logic [1:0] SLOT_CONTROL = 2'd2;
    localparam logic [1:0] SLOT_ENABLE  = 2'd0;
    localparam logic [1:0] SLOT_IRQ     = 2'd1;

    // channel control words that start a transfer
    localparam logic [31:0] MODE_READ_BLOCK    = 32'h0100_0200;
    localparam logic [31:0] MODE_WRITE_BLOCK   = 32'h0100_0201;
    localparam logic [31:0] MODE_LINKED_LIST   = 32'h0100_0401;
    localparam logic [31:0] MODE_REVERSE_CLEAR = 32'h1100_0002;
    localparam logic [2:0]  CH_BLOCK_XFER      = 3'd2;
    localparam logic [2:0]  CH_REVERSE_CLEAR   = 3'd6;

    localparam logic [1:0] XMODE_TO_MEM    = 2'd0;
    localparam logic [1:0] XMODE_FROM_MEM  = 2'd1;
    localparam logic [1:0] XMODE_LINKED    = 2'd2;
    localparam logic [1:0] XMODE_REV_CLEAR = 2'd3;

    localparam int          BUSY_BIT        = 24;
    localparam int          DMA_MASTER_BIT  = 31;
    localparam logic [31:0] IRQ_DMA_BIT     = 32'h0000_0008;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  reg_offset;
        logic [31:0] write_data;
        logic [31:0] keep_mask;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        start_transfer;
        logic [2:0]  xfer_channel;
        logic [1:0]  xfer_mode;
        logic [23:0] xfer_address;
        logic [31:0] xfer_block_control;
    } result_t;

    typedef struct packed {
        logic        commit;
        logic        wr;
        logic [4:0]  reg_offset;
        logic [31:0] write_data;
        logic [31:0] keep_mask;
    } dma_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        start;
        logic [2:0]  channel;
        logic [1:0]  mode;
        logic [23:0] address;
        logic [31:0] block_control;
        logic        raise_irq;
    } dma_rsp_t;

endpackage

`default_nettype wire

### rtl/iadc_dma_regs.sv
// dma channel registers, enable and interrupt words, transfer mode decode
// depends on iadc_pkg
`default_nettype none

module iadc_dma_regs (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iadc_pkg::dma_req_t  req,
    output iadc_pkg::dma_rsp_t       rsp
);

    logic [31:0] chan_base_reg    [iadc_pkg::NUM_CHANNELS];
    logic [31:0] chan_block_reg   [iadc_pkg::NUM_CHANNELS];
    logic [31:0] chan_control_reg [iadc_pkg::NUM_CHANNELS];
    logic [31:0] dma_enable_reg, dma_enable_next;
    logic [31:0] dma_irq_reg, dma_irq_next;

    logic [2:0]              ch;
    logic [1:0]              slot;
    logic                    is_chan;
    logic [iadc_pkg::CH_W-1:0] idx;
    logic                    ctl_wr;
    logic                    go;
    logic                    known;
    logic [1:0]              mode;
    logic [31:0]             ctl_word;
    logic                    irq_hit;

    assign ch      = req.reg_offset[4:2];
    assign slot    = req.reg_offset[1:0];
    assign is_chan = ({1'b0, ch} < iadc_pkg::NUM_CH_CMP);
    assign idx     = ch[iadc_pkg::CH_W-1:0];
    assign ctl_wr  = req.wr && is_chan && (slot == iadc_pkg::SLOT_CONTROL);

    // mode decode for a busy control write on an enabled channel
    always_comb begin
        known = 1'b1;
        mode  = iadc_pkg::XMODE_TO_MEM;
        if (ch == iadc_pkg::CH_BLOCK_XFER && req.write_data == iadc_pkg::MODE_READ_BLOCK) begin
            mode = iadc_pkg::XMODE_TO_MEM;
        end else if (ch == iadc_pkg::CH_BLOCK_XFER &&
                     req.write_data == iadc_pkg::MODE_WRITE_BLOCK) begin
            mode = iadc_pkg::XMODE_FROM_MEM;
        end else if (ch == iadc_pkg::CH_BLOCK_XFER &&
                     req.write_data == iadc_pkg::MODE_LINKED_LIST) begin
            mode = iadc_pkg::XMODE_LINKED;
        end else if (ch == iadc_pkg::CH_REVERSE_CLEAR &&
                     req.write_data == iadc_pkg::MODE_REVERSE_CLEAR) begin
            mode = iadc_pkg::XMODE_REV_CLEAR;
        end else begin
            known = 1'b0;
        end
    end

    // enable bit of channel n sits at 4n+3, its irq enable at 16+n, its flag at 24+n
    assign go      = ctl_wr && req.write_data[iadc_pkg::BUSY_BIT] && dma_enable_reg[{ch, 2'b11}];
    assign irq_hit = go && dma_irq_reg[{2'b10, ch}];

    always_comb begin
        ctl_word = req.write_data;
        if (go && known) begin
            ctl_word[iadc_pkg::BUSY_BIT] = 1'b0;
        end
    end

    always_comb begin
        dma_enable_next = dma_enable_reg;
        dma_irq_next    = dma_irq_reg;
        if (req.wr && !is_chan && slot == iadc_pkg::SLOT_ENABLE) begin
            dma_enable_next = (dma_enable_reg & req.keep_mask) | req.write_data;
        end
        if (req.wr && !is_chan && slot == iadc_pkg::SLOT_IRQ) begin
            dma_irq_next = (dma_irq_reg & req.keep_mask) | {8'h00, req.write_data[23:0]};
        end
        if (irq_hit) begin
            dma_irq_next[iadc_pkg::DMA_MASTER_BIT] = 1'b1;
            dma_irq_next[{2'b11, ch}]              = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dma_enable_reg <= '0;
            dma_irq_reg    <= '0;
        end else if (req.commit) begin
            dma_enable_reg <= dma_enable_next;
            dma_irq_reg    <= dma_irq_next;
        end
    end

    // channel words have no reset value
    always_ff @(posedge aclk) begin
        if (req.commit && req.wr && is_chan) begin
            case (slot)
                iadc_pkg::SLOT_BASE:    chan_base_reg[idx]    <= req.write_data;
                iadc_pkg::SLOT_BLOCK:   chan_block_reg[idx]   <= req.write_data;
                iadc_pkg::SLOT_CONTROL: chan_control_reg[idx] <= ctl_word;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rsp = '0;
        if (is_chan) begin
            case (slot)
                iadc_pkg::SLOT_BASE:    rsp.read_data = chan_base_reg[idx];
                iadc_pkg::SLOT_BLOCK:   rsp.read_data = chan_block_reg[idx];
                iadc_pkg::SLOT_CONTROL: rsp.read_data = chan_control_reg[idx];
                default:                rsp.read_data = '0;
            endcase
        end else begin
            case (slot)
                iadc_pkg::SLOT_ENABLE: rsp.read_data = dma_enable_reg;
                iadc_pkg::SLOT_IRQ:    rsp.read_data = dma_irq_reg;
                default:               rsp.read_data = '0;
            endcase
        end
        if (go && known) begin
            rsp.start         = 1'b1;
            rsp.channel       = ch;
            rsp.mode          = mode;
            rsp.address       = chan_base_reg[idx][23:0];
            rsp.block_control = chan_block_reg[idx];
        end
        rsp.raise_irq = irq_hit;
    end

endmodule

`default_nettype wire

### rtl/irq_and_dma_control_registers.sv
// top level: interrupt status/enable registers, stream ports, result register
// depends on iadc_pkg and iadc_dma_regs
`default_nettype none

// Register block for an interrupt controller and seven dma channels, driven as a
// stream: each input word is one bus access (irq or dma read/write) or an event
// that raises interrupt status bits, and each produces exactly one output word
// with the read data, the irq line level after the access, and a transfer-start
// command when a channel control write launches a recognized dma mode. Words are
// taken into an input register, decoded and applied by short combinational logic,
// and the answer is registered in an output register when that slot is free.
// While the output drains, one word is accepted every cycle. The state update is
// done when a word moves into the output register, so a stalled output only
// holds the pipe and never loses or repeats a word. Channel base, block and
// control words have no reset value and must be written before being read or
// used by a transfer.

module irq_and_dma_control_registers (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] reg_offset, [36:5] write_data, [68:37] keep_mask, [71:69] zero
    input  wire logic [71:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] read_data, [32] irq_line, [35:33] xfer_channel, [37:36] xfer_mode,
    // [61:38] xfer_address, [93:62] xfer_block_control, [95:94] zero
    output logic [95:0]      m_tdata,
    // [0] start_transfer
    output logic [0:0]       m_tuser
);

    // input register
    logic              in_valid_reg;
    iadc_pkg::item_t   in_item_reg;
    // output register
    logic              out_valid_reg;
    iadc_pkg::result_t out_reg;
    iadc_pkg::result_t res;

    // interrupt state
    logic [31:0] irq_status_reg, irq_status_next;
    logic [31:0] irq_enable_reg, irq_enable_next;
    logic        irq_level_reg, irq_level_next;

    logic               advance;
    iadc_pkg::dma_req_t dma_req;
    iadc_pkg::dma_rsp_t dma_rsp;
    logic [31:0]        raise;

    // the word in the input register moves on when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign dma_req.commit     = advance;
    assign dma_req.wr         = (in_item_reg.action == iadc_pkg::ACT_DMA_WR);
    assign dma_req.reg_offset = in_item_reg.reg_offset;
    assign dma_req.write_data = in_item_reg.write_data;
    assign dma_req.keep_mask  = in_item_reg.keep_mask;

    iadc_dma_regs u_dma (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dma_req),
        .rsp     (dma_rsp)
    );

    // interrupt register update and read mux
    always_comb begin
        irq_status_next = irq_status_reg;
        irq_enable_next = irq_enable_reg;
        irq_level_next  = irq_level_reg;
        raise           = '0;
        res             = '0;
        case (in_item_reg.action)
            iadc_pkg::ACT_IRQ_WR: begin
                if (in_item_reg.reg_offset == iadc_pkg::IRQ_OFF_STATUS) begin
                    // acknowledge: only enabled bits can survive the data mask
                    irq_status_next = (irq_status_reg & in_item_reg.keep_mask) |
                                      (irq_status_reg & irq_enable_reg &
                                       in_item_reg.write_data);
                    if ((irq_status_next & irq_enable_reg) == '0) begin
                        irq_level_next = 1'b0;
                    end
                end else if (in_item_reg.reg_offset == iadc_pkg::IRQ_OFF_ENABLE) begin
                    irq_enable_next = (irq_enable_reg & in_item_reg.keep_mask) |
                                      in_item_reg.write_data;
                    if ((irq_status_reg & irq_enable_next) != '0) begin
                        irq_level_next = 1'b1;
                    end
                end
            end
            iadc_pkg::ACT_IRQ_RD: begin
                if (in_item_reg.reg_offset == iadc_pkg::IRQ_OFF_STATUS) begin
                    res.read_data = irq_status_reg;
                end else if (in_item_reg.reg_offset == iadc_pkg::IRQ_OFF_ENABLE) begin
                    res.read_data = irq_enable_reg;
                end
            end
            iadc_pkg::ACT_DMA_WR: begin
                if (dma_rsp.raise_irq) begin
                    raise = iadc_pkg::IRQ_DMA_BIT;
                end
                res.start_transfer     = dma_rsp.start;
                res.xfer_channel       = dma_rsp.channel;
                res.xfer_mode          = dma_rsp.mode;
                res.xfer_address       = dma_rsp.address;
                res.xfer_block_control = dma_rsp.block_control;
            end
            iadc_pkg::ACT_DMA_RD: begin
                res.read_data = dma_rsp.read_data;
            end
            iadc_pkg::ACT_RAISE: begin
                raise = in_item_reg.write_data;
            end
            default: begin
            end
        endcase
        // raised bits set status; the line goes high if any is enabled
        if (raise != '0) begin
            irq_status_next = irq_status_reg | raise;
            if ((irq_status_next & irq_enable_reg) != '0) begin
                irq_level_next = 1'b1;
            end
        end
        res.irq_line = irq_level_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            irq_status_reg <= '0;
            irq_enable_reg <= '0;
            irq_level_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                irq_status_reg <= irq_status_next;
                irq_enable_reg <= irq_enable_next;
                irq_level_reg  <= irq_level_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action     <= s_tuser;
            in_item_reg.reg_offset <= s_tdata[4:0];
            in_item_reg.write_data <= s_tdata[36:5];
            in_item_reg.keep_mask  <= s_tdata[68:37];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.xfer_block_control, out_reg.xfer_address,
                       out_reg.xfer_mode, out_reg.xfer_channel, out_reg.irq_line,
                       out_reg.read_data};
    assign m_tuser  = out_reg.start_transfer;

    // the reported line level is the level left by that word
    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_reg.irq_line == irq_level_reg))
        else $error("irq_line in result differs from stored level");

    // a started transfer uses a mode that belongs to its channel
    a_mode_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.start_transfer) |->
            ((out_reg.xfer_mode == iadc_pkg::XMODE_REV_CLEAR &&
              out_reg.xfer_channel == iadc_pkg::CH_REVERSE_CLEAR) ||
             (out_reg.xfer_mode != iadc_pkg::XMODE_REV_CLEAR &&
              out_reg.xfer_channel == iadc_pkg::CH_BLOCK_XFER)))
        else $error("transfer mode does not match channel");

    // a held input word is not dropped while the output is stalled
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost while stalled");

endmodule

`default_nettype wire

### bench/irq_and_dma_control_registers_tb.sv
// self-checking bench for the irq and dma control register block
// depends on iadc_pkg and the irq_and_dma_control_registers rtl
// a scoreboard class predicts each result word
`timescale 1ns / 1ps

module irq_and_dma_control_registers_tb;

    // bit positions inside the dma enable and dma interrupt words
    localparam int EN_BIT_BASE   = 3;   // channel enable, stride four
    localparam int EN_BIT_STRIDE = 4;
    localparam int IE_BIT_BASE   = 16;  // channel interrupt enable
    localparam int IF_BIT_BASE   = 24;  // channel interrupt flag

    localparam logic [2:0] CTRL_GROUP  = 3'd7;  // channel index of the control words
    localparam logic [1:0] SLOT_UNUSED = 2'd3;

    // action codes with no meaning
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_WORDS = 800;
    localparam int QUIET_TAIL   = 150;   // last words run with no idling
    localparam int LONG_STALL   = 300;

    // scoreboard: own copy of the register state, predicts one result per word
    class dma_irq_scoreboard;
        logic [31:0]       status, enable;
        logic              line;
        logic [31:0]       base [iadc_pkg::NUM_CHANNELS];
        logic [31:0]       blk  [iadc_pkg::NUM_CHANNELS];
        logic [31:0]       ctrl [iadc_pkg::NUM_CHANNELS];
        logic [31:0]       en_word, int_word;
        iadc_pkg::result_t pending[$];
        int                checked, mismatches, starts;

        function new();
            status = '0; enable = '0; line = 1'b0;
            en_word = '0; int_word = '0;
            checked = 0; mismatches = 0; starts = 0;
        endfunction

        function void raise_status(logic [31:0] bits);
            status |= bits;
            if ((status & enable) != 0) line = 1'b1;
        endfunction

        function iadc_pkg::result_t next_result(iadc_pkg::item_t it);
            iadc_pkg::result_t r;
            logic [2:0]        ch;
            logic [1:0]        slot, mode;
            logic [31:0]       d, k;
            bit                known;
            int                chi;
            r = '0;
            ch = it.reg_offset[4:2];
            chi = ch;
            slot = it.reg_offset[1:0];
            d = it.write_data;
            k = it.keep_mask;
            case (it.action)
                iadc_pkg::ACT_IRQ_WR: begin
                    if (it.reg_offset == iadc_pkg::IRQ_OFF_STATUS) begin
                        status = (status & k) | (status & enable & d);
                        if ((status & enable) == 0) line = 1'b0;
                    end else if (it.reg_offset == iadc_pkg::IRQ_OFF_ENABLE) begin
                        enable = (enable & k) | d;
                        if ((status & enable) != 0) line = 1'b1;
                    end
                end
                iadc_pkg::ACT_IRQ_RD: begin
                    if (it.reg_offset == iadc_pkg::IRQ_OFF_STATUS) r.read_data = status;
                    else if (it.reg_offset == iadc_pkg::IRQ_OFF_ENABLE) r.read_data = enable;
                end
                iadc_pkg::ACT_DMA_WR: begin
                    if ({1'b0, ch} < iadc_pkg::NUM_CH_CMP) begin
                        if (slot == iadc_pkg::SLOT_BASE) begin
                            base[chi] = d;
                        end else if (slot == iadc_pkg::SLOT_BLOCK) begin
                            blk[chi] = d;
                        end else if (slot == iadc_pkg::SLOT_CONTROL) begin
                            if (d[iadc_pkg::BUSY_BIT] &&
                                en_word[EN_BIT_BASE + chi * EN_BIT_STRIDE]) begin
                                known = 1'b1;
                                mode = iadc_pkg::XMODE_TO_MEM;
                                if (ch == iadc_pkg::CH_BLOCK_XFER &&
                                    d == iadc_pkg::MODE_READ_BLOCK)
                                    mode = iadc_pkg::XMODE_TO_MEM;
                                else if (ch == iadc_pkg::CH_BLOCK_XFER &&
                                         d == iadc_pkg::MODE_WRITE_BLOCK)
                                    mode = iadc_pkg::XMODE_FROM_MEM;
                                else if (ch == iadc_pkg::CH_BLOCK_XFER &&
                                         d == iadc_pkg::MODE_LINKED_LIST)
                                    mode = iadc_pkg::XMODE_LINKED;
                                else if (ch == iadc_pkg::CH_REVERSE_CLEAR &&
                                         d == iadc_pkg::MODE_REVERSE_CLEAR)
                                    mode = iadc_pkg::XMODE_REV_CLEAR;
                                else
                                    known = 1'b0;
                                if (known) begin
                                    r.start_transfer = 1'b1;
                                    r.xfer_channel = ch;
                                    r.xfer_mode = mode;
                                    r.xfer_address = base[chi][23:0];
                                    r.xfer_block_control = blk[chi];
                                    d[iadc_pkg::BUSY_BIT] = 1'b0;
                                    starts++;
                                end
                                if (int_word[IE_BIT_BASE + chi]) begin
                                    int_word[iadc_pkg::DMA_MASTER_BIT] = 1'b1;
                                    int_word[IF_BIT_BASE + chi] = 1'b1;
                                    raise_status(iadc_pkg::IRQ_DMA_BIT);
                                end
                            end
                            ctrl[chi] = d;
                        end
                    end else begin
                        if (slot == iadc_pkg::SLOT_ENABLE)
                            en_word = (en_word & k) | d;
                        else if (slot == iadc_pkg::SLOT_IRQ)
                            int_word = (int_word & k) | {8'h00, d[23:0]};
                    end
                end
                iadc_pkg::ACT_DMA_RD: begin
                    if ({1'b0, ch} < iadc_pkg::NUM_CH_CMP) begin
                        if (slot == iadc_pkg::SLOT_BASE) r.read_data = base[chi];
                        else if (slot == iadc_pkg::SLOT_BLOCK) r.read_data = blk[chi];
                        else if (slot == iadc_pkg::SLOT_CONTROL) r.read_data = ctrl[chi];
                    end else begin
                        if (slot == iadc_pkg::SLOT_ENABLE) r.read_data = en_word;
                        else if (slot == iadc_pkg::SLOT_IRQ) r.read_data = int_word;
                    end
                end
                iadc_pkg::ACT_RAISE: raise_status(d);
                default: ;
            endcase
            r.irq_line = line;
            return r;
        endfunction

        function void note_input(iadc_pkg::item_t it);
            pending.push_back(next_result(it));
        endfunction

        function void check_result(iadc_pkg::result_t got);
            iadc_pkg::result_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing expected: %h", $time, got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.read_data !== exp.read_data || got.irq_line !== exp.irq_line ||
                got.start_transfer !== exp.start_transfer ||
                got.xfer_channel !== exp.xfer_channel || got.xfer_mode !== exp.xfer_mode ||
                got.xfer_address !== exp.xfer_address ||
                got.xfer_block_control !== exp.xfer_block_control) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch on result %0d", $time, checked);
                    $display("  expected rd=%h irq=%b start=%b ch=%0d mode=%0d addr=%h blk=%h",
                             exp.read_data, exp.irq_line, exp.start_transfer,
                             exp.xfer_channel, exp.xfer_mode, exp.xfer_address,
                             exp.xfer_block_control);
                    $display("  actual   rd=%h irq=%b start=%b ch=%0d mode=%0d addr=%h blk=%h",
                             got.read_data, got.irq_line, got.start_transfer,
                             got.xfer_channel, got.xfer_mode, got.xfer_address,
                             got.xfer_block_control);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [4:0] reg_offset, [36:5] write_data, [68:37] keep_mask
    logic [2:0]  s_tuser;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // [31:0] read_data, [32] irq_line, [35:33] channel, [37:36] mode,
                            // [61:38] address, [93:62] block control
    logic [0:0]  m_tuser;   // [0] start_transfer

    dma_irq_scoreboard sb;
    int  words_sent;
    bit  idle_on;          // random gaps on both sides
    bit  long_stall_req;   // receiver holds off for a long stretch
    int  long_stalls_done;

    irq_and_dma_control_registers uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic iadc_pkg::item_t mk(logic [2:0] a, logic [4:0] off, logic [31:0] d,
                                           logic [31:0] k);
        iadc_pkg::item_t it;
        it.action = a;
        it.reg_offset = off;
        it.write_data = d;
        it.keep_mask = k;
        return it;
    endfunction

    // offer one word, hold it until the handshake, then hand it to the scoreboard
    task automatic send_word(input iadc_pkg::item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {3'b000, it.keep_mask, it.write_data, it.reg_offset};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        words_sent++;
    endtask

    function automatic logic [31:0] rand_keep();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // unstructured word: any action, offset and data, biased toward the live registers
    function automatic iadc_pkg::item_t rand_word();
        logic [2:0]  a;
        logic [4:0]  off;
        logic [31:0] d;
        int          r;
        r = $urandom_range(0, 15);
        a = (r < 14) ? 3'(r % 5)
                     : 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        if ((a == iadc_pkg::ACT_IRQ_WR || a == iadc_pkg::ACT_IRQ_RD) &&
            $urandom_range(0, 3) != 0)
            off = 5'($urandom_range(0, 1));
        else
            off = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: d = iadc_pkg::MODE_READ_BLOCK;
                    1: d = iadc_pkg::MODE_WRITE_BLOCK;
                    2: d = iadc_pkg::MODE_LINKED_LIST;
                    default: d = iadc_pkg::MODE_REVERSE_CLEAR;
                endcase
            end
            1: d = '0;
            2: d = '1;
            3: d = $urandom | (32'd1 << iadc_pkg::BUSY_BIT);
            default: d = $urandom;
        endcase
        if (a == iadc_pkg::ACT_RAISE && $urandom_range(0, 1) == 0)
            d = $urandom & $urandom & $urandom;
        return mk(a, off, d, rand_keep());
    endfunction

    // the sequence that gets a channel to start: base, block, enables, then a control word and read-backs
    task automatic send_transfer_sequence();
        logic [2:0]  ch;
        logic [31:0] ctl;
        int          chi;
        if ($urandom_range(0, 3) == 0)
            ch = 3'($urandom_range(0, iadc_pkg::NUM_CHANNELS - 1));
        else
            ch = $urandom_range(0, 1) ? iadc_pkg::CH_BLOCK_XFER : iadc_pkg::CH_REVERSE_CLEAR;
        chi = ch;
        send_word(mk(iadc_pkg::ACT_DMA_WR, {ch, iadc_pkg::SLOT_BASE}, $urandom, $urandom));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {ch, iadc_pkg::SLOT_BLOCK}, $urandom, $urandom));
        if ($urandom_range(0, 2) == 0)
            send_word(mk(iadc_pkg::ACT_DMA_WR, {CTRL_GROUP, iadc_pkg::SLOT_ENABLE},
                         ($urandom_range(0, 4) != 0)
                             ? $urandom | (32'd1 << (EN_BIT_BASE + chi * EN_BIT_STRIDE))
                             : $urandom,
                         rand_keep()));
        if ($urandom_range(0, 2) == 0)
            send_word(mk(iadc_pkg::ACT_DMA_WR, {CTRL_GROUP, iadc_pkg::SLOT_IRQ},
                         ($urandom_range(0, 1) != 0) ? $urandom | (32'd1 << (IE_BIT_BASE + chi))
                                                     : $urandom,
                         rand_keep()));
        if ($urandom_range(0, 4) == 0)
            send_word(mk(iadc_pkg::ACT_IRQ_WR, iadc_pkg::IRQ_OFF_ENABLE,
                         $urandom | iadc_pkg::IRQ_DMA_BIT, rand_keep()));
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                if (ch == iadc_pkg::CH_REVERSE_CLEAR) ctl = iadc_pkg::MODE_REVERSE_CLEAR;
                else if ($urandom_range(0, 2) == 0) ctl = iadc_pkg::MODE_READ_BLOCK;
                else ctl = $urandom_range(0, 1) ? iadc_pkg::MODE_WRITE_BLOCK
                                                : iadc_pkg::MODE_LINKED_LIST;
            end
            3: ctl = iadc_pkg::MODE_READ_BLOCK;
            4: ctl = iadc_pkg::MODE_REVERSE_CLEAR;
            5: ctl = $urandom | (32'd1 << iadc_pkg::BUSY_BIT);
            default: ctl = $urandom;
        endcase
        send_word(mk(iadc_pkg::ACT_DMA_WR, {ch, iadc_pkg::SLOT_CONTROL}, ctl, $urandom));
        send_word(mk(iadc_pkg::ACT_DMA_RD, {ch, iadc_pkg::SLOT_CONTROL}, $urandom, $urandom));
        if ($urandom_range(0, 1) == 0)
            send_word(mk(iadc_pkg::ACT_DMA_RD, {CTRL_GROUP, iadc_pkg::SLOT_IRQ},
                         $urandom, $urandom));
        if ($urandom_range(0, 1) == 0)
            send_word(mk(iadc_pkg::ACT_IRQ_RD, iadc_pkg::IRQ_OFF_STATUS, $urandom, $urandom));
        if ($urandom_range(0, 2) == 0)
            send_word(mk(iadc_pkg::ACT_IRQ_WR, iadc_pkg::IRQ_OFF_STATUS, $urandom,
                         rand_keep()));
    endtask

    // result monitor: every accepted output word goes to the scoreboard
    always @(posedge aclk) begin
        iadc_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_data          = m_tdata[31:0];
            got.irq_line           = m_tdata[32];
            got.xfer_channel       = m_tdata[35:33];
            got.xfer_mode          = m_tdata[37:36];
            got.xfer_address       = m_tdata[61:38];
            got.xfer_block_control = m_tdata[93:62];
            got.start_transfer     = m_tuser[0];
            sb.check_result(got);
        end
    end

    // receiver: random back-pressure bursts, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                long_stall_req = 1'b0;
                long_stalls_done++;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("timeout with %0d results still expected", sb.pending.size());
        $display("** irq_and_dma_control_registers: FAILED **");
        $finish;
    end

    initial begin
        int ch;
        int target;
        sb = new();
        words_sent = 0;
        idle_on = 1'b0;
        long_stall_req = 1'b0;
        long_stalls_done = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bring every channel entry to a defined value before anything reads it
        for (ch = 0; ch < iadc_pkg::NUM_CHANNELS; ch++) begin
            send_word(mk(iadc_pkg::ACT_DMA_WR, {3'(ch), iadc_pkg::SLOT_BASE},
                         $urandom, $urandom));
            send_word(mk(iadc_pkg::ACT_DMA_WR, {3'(ch), iadc_pkg::SLOT_BLOCK},
                         $urandom, $urandom));
            send_word(mk(iadc_pkg::ACT_DMA_WR, {3'(ch), iadc_pkg::SLOT_CONTROL},
                         $urandom, $urandom));
        end

        // directed: irq status and enable, masked writes, line set and clear
        send_word(mk(iadc_pkg::ACT_RAISE, 5'd0, '1, '0));
        send_word(mk(iadc_pkg::ACT_IRQ_RD, iadc_pkg::IRQ_OFF_STATUS, '0, '0));
        // line goes high
        send_word(mk(iadc_pkg::ACT_IRQ_WR, iadc_pkg::IRQ_OFF_ENABLE, 32'h0000_00ff, '0));
        // ack all enabled bits
        send_word(mk(iadc_pkg::ACT_IRQ_WR, iadc_pkg::IRQ_OFF_STATUS, 32'h0000_0f00, '0));
        // keep everything
        send_word(mk(iadc_pkg::ACT_IRQ_WR, iadc_pkg::IRQ_OFF_ENABLE, '0, '1));
        send_word(mk(iadc_pkg::ACT_IRQ_RD, iadc_pkg::IRQ_OFF_ENABLE, '1, '1));
        send_word(mk(iadc_pkg::ACT_IRQ_WR, 5'd31, '1, '0));   // unknown irq offset
        send_word(mk(iadc_pkg::ACT_IRQ_RD, 5'd31, '1, '1));
        // directed: dma control words, only low 24 bits of the interrupt word taken
        send_word(mk(iadc_pkg::ACT_DMA_WR, {CTRL_GROUP, iadc_pkg::SLOT_ENABLE}, '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {CTRL_GROUP, iadc_pkg::SLOT_IRQ}, '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_RD, {CTRL_GROUP, iadc_pkg::SLOT_IRQ}, '0, '0));
        // base ignores keep
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, iadc_pkg::SLOT_BASE},
                     '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, iadc_pkg::SLOT_BLOCK},
                     '1, '1));
        // directed: every recognized mode, then an unknown mode with the busy bit
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, iadc_pkg::SLOT_CONTROL},
                     iadc_pkg::MODE_READ_BLOCK, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, iadc_pkg::SLOT_CONTROL},
                     iadc_pkg::MODE_WRITE_BLOCK, '1));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, iadc_pkg::SLOT_CONTROL},
                     iadc_pkg::MODE_LINKED_LIST, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR,
                     {iadc_pkg::CH_REVERSE_CLEAR, iadc_pkg::SLOT_CONTROL},
                     iadc_pkg::MODE_REVERSE_CLEAR, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR,
                     {iadc_pkg::CH_REVERSE_CLEAR, iadc_pkg::SLOT_CONTROL},
                     iadc_pkg::MODE_READ_BLOCK, '0));
        send_word(mk(iadc_pkg::ACT_DMA_RD,
                     {iadc_pkg::CH_REVERSE_CLEAR, iadc_pkg::SLOT_CONTROL}, '0, '0));
        // unused slots
        send_word(mk(iadc_pkg::ACT_DMA_WR, {iadc_pkg::CH_BLOCK_XFER, SLOT_UNUSED}, '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_RD, {iadc_pkg::CH_BLOCK_XFER, SLOT_UNUSED}, '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_WR, {CTRL_GROUP, SLOT_UNUSED}, '1, '0));
        send_word(mk(iadc_pkg::ACT_DMA_RD, {CTRL_GROUP, iadc_pkg::SLOT_CONTROL}, '1, '0));
        // unknown actions
        send_word(mk(ACT_UNUSED_FIRST, 5'd31, '1, '1));
        send_word(mk(ACT_UNUSED_LAST, 5'd0, '1, '0));

        // random part: mostly transfer sequences with random content, the rest noise
        idle_on = 1'b1;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if (target - words_sent < QUIET_TAIL) idle_on = 1'b0;
            if (long_stalls_done == 0 && !long_stall_req &&
                target - words_sent < RANDOM_WORDS / 2)
                long_stall_req = 1'b1;   // output held off while words keep coming
            if ($urandom_range(0, 9) < 6) send_transfer_sequence();
            else send_word(rand_word());
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d words, %0d results checked, %0d transfers started,",
                 words_sent, sb.checked, sb.starts);
        $display("random idling on both sides and %0d long output hold-off", long_stalls_done);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("** irq_and_dma_control_registers: PASSED **");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("** irq_and_dma_control_registers: FAILED **");
        end
        $finish;
    end

endmodule
